// ----- src/sensor_mlp_wheel_drive_unit_macros.svh -----
// Assertion macros shared by the wheel drive unit and its submodules.
`ifndef SENSOR_MLP_WHEEL_DRIVE_UNIT_MACROS_SVH
`define SENSOR_MLP_WHEEL_DRIVE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMWD_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMWD_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smwd_pkg.sv -----
// Package with the sizes, types and helper functions of the wheel drive unit.
package smwd_pkg;

  // Network shape.
  localparam int NUM_IN      = 8;
  localparam int NUM_OUT     = 2;
  localparam int NUM_HIDDEN  = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int OUT_BASE    = NUM_IN * NUM_HIDDEN;
  localparam int STORE_DEPTH = OUT_BASE + NUM_OUT * NUM_HIDDEN;

  // Each neuron keeps its own weight bank; the tanh lanes cover the widest layer.
  localparam int BANK_DEPTH = (NUM_HIDDEN > NUM_IN) ? NUM_HIDDEN : NUM_IN;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int CNT_W      = $clog2(BANK_DEPTH + 1);

  // Field and datapath widths.
  localparam int SENSOR_W = 12;
  localparam int IDX_W    = 6;
  localparam int WIN_W    = 16;
  localparam int SPEED_W  = 11;
  localparam int ACT_W    = 14;
  localparam int PRE_W    = 16;
  localparam int PROD_W   = ACT_W + WEIGHT_BITS;
  localparam int ACC_W    = PROD_W + CNT_W;

  // Input scaling: floor((4096*(v-50)+95)/190) - 10240 inside the window.
  localparam int SCALE_LO   = 50;
  localparam int SCALE_HI   = 1000;
  localparam int SCALE_FULL = 10240;
  localparam int SCALE_OFS  = 95;
  localparam int DIV_C      = 190;
  localparam int RECIP_M    = 5651272;
  localparam int RECIP_SH   = 30;

  // Activation constants.
  localparam int ONE_Q12  = 4096;
  localparam int TANH_SAT = 12288;
  localparam logic [29:0] PADE_K = 30'd452984832;
  localparam int RND_HALF = 512;
  localparam int RND_SH   = 10;
  localparam int SPEED_SCALE = 1000;

  typedef logic signed [ACT_W-1:0]       act_t;
  typedef logic signed [PRE_W-1:0]       pre_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic [BANK_AW-1:0]            bank_addr_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [SENSOR_W-1:0]           sensor_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic signed [WIN_W-1:0]       win_t;
  typedef logic signed [SPEED_W-1:0]     speed_t;

  localparam act_t   ACT_ONE   = act_t'(ONE_Q12);
  localparam speed_t SPEED_MAX = speed_t'(SPEED_SCALE);

  // Write port of one neuron's weight bank.
  typedef struct packed {
    logic       en;
    bank_addr_t addr;
    weight_t    data;
  } wr_t;

  // Clamp an incoming weight to the signed range of the store.
  function automatic weight_t sat_weight(input win_t w);
    logic signed [24:0] wx;
    logic signed [24:0] hi;
    logic signed [24:0] lo;
    wx = 25'(w);
    hi = (25'sd1 <<< (WEIGHT_BITS - 1)) - 25'sd1;
    lo = -hi - 25'sd1;
    if (wx > hi) begin
      return WEIGHT_BITS'(hi);
    end else if (wx < lo) begin
      return WEIGHT_BITS'(lo);
    end
    return WEIGHT_BITS'(wx);
  endfunction

endpackage

// ----- src/smwd_tanh.sv -----
// Iterative Pade tanh unit: square, numerator, then a 13-step restoring divide.
`include "sensor_mlp_wheel_drive_unit_macros.svh"

module smwd_tanh (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  smwd_pkg::pre_t x_i,
  output smwd_pkg::act_t res_o,
  output logic          valid_o
);
  import smwd_pkg::*;

  localparam int QBITS = 13;
  localparam int NUM_W = 44;
  localparam int D_W   = 31;
  localparam int STEP_W = $clog2(QBITS);

  typedef enum logic [1:0] {T_IDLE, T_SQ, T_NUM, T_DIV} tstate_t;

  tstate_t            state_r;
  logic               neg_r;
  logic [13:0]        a_r;
  logic [27:0]        s_r;
  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   dsh_r;
  logic [QBITS-1:0]   q_r;
  logic [STEP_W-1:0]  step_r;
  act_t               res_r;
  logic               valid_r;

  logic signed [16:0] xe;
  logic [16:0]        a_full;
  logic [29:0]        kps;
  logic [D_W-1:0]     d_val;
  logic [NUM_W-1:0]   num_val;
  logic               ge;
  logic [QBITS-1:0]   q_fin;

  // Magnitude of the operand and the Pade numerator and denominator.
  always_comb begin
    xe      = 17'(x_i);
    a_full  = xe[16] ? 17'(-xe) : 17'(xe);
    kps     = PADE_K + 30'(s_r);
    d_val   = D_W'(PADE_K) + D_W'({s_r, 3'b000}) + D_W'(s_r);
    num_val = NUM_W'(a_r) * NUM_W'(kps) + NUM_W'(d_val >> 1);
    ge      = (num_r >= dsh_r);
    q_fin   = {q_r[QBITS-2:0], ge};
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (start_i) begin
            neg_r <= xe[16];
            a_r   <= a_full[13:0];
            if (a_full >= 17'(TANH_SAT)) begin
              res_r   <= xe[16] ? -ACT_ONE : ACT_ONE;
              valid_r <= 1'b1;
            end else begin
              valid_r <= 1'b0;
              state_r <= T_SQ;
            end
          end
        end
        T_SQ: begin
          s_r     <= 28'(a_r) * 28'(a_r);
          state_r <= T_NUM;
        end
        T_NUM: begin
          num_r   <= num_val;
          dsh_r   <= NUM_W'(d_val) << (QBITS - 1);
          q_r     <= '0;
          step_r  <= '0;
          state_r <= T_DIV;
        end
        T_DIV: begin
          if (ge) begin
            num_r <= num_r - dsh_r;
          end
          dsh_r  <= dsh_r >> 1;
          q_r    <= q_fin;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(QBITS - 1)) begin
            res_r   <= neg_r ? -act_t'(q_fin) : act_t'(q_fin);
            valid_r <= 1'b1;
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign res_o   = res_r;
  assign valid_o = valid_r;

  `SMWD_NEXT(a_start_clears, start_i && (state_r == T_IDLE) && (a_full < 17'(TANH_SAT)), !valid_o, "tanh result still flagged after a new start")
  `SMWD_HOLD(a_res_range, valid_o, (res_o <= ACT_ONE) && (res_o >= -ACT_ONE), "tanh result beyond one")
  `SMWD_HOLD(a_busy_invalid, state_r != T_IDLE, !valid_o, "tanh result flagged while dividing")

endmodule

// ----- src/smwd_neuron.sv -----
// One neuron lane: private weight bank, serial multiply-accumulate, round and saturate.
module smwd_neuron (
  input  logic           clk,
  input  logic           rst_n,
  input  smwd_pkg::wr_t  wr_i,
  input  logic           start_i,
  input  smwd_pkg::cnt_t terms_i,
  input  smwd_pkg::act_t act_i [smwd_pkg::BANK_DEPTH],
  output smwd_pkg::pre_t sum_o,
  output logic           valid_o
);
  import smwd_pkg::*;

  weight_t                  bank_r [BANK_DEPTH];
  logic                     busy_r;
  logic                     valid_r;
  cnt_t                     cnt_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shifted;

  // Weight bank, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANK_DEPTH; i++) begin
        bank_r[i] <= '0;
      end
    end else if (wr_i.en) begin
      bank_r[wr_i.addr] <= wr_i.data;
    end
  end

  // One product per cycle, and the rounded, saturated sum.
  always_comb begin
    prod    = PROD_W'(act_i[cnt_r[BANK_AW-1:0]]) * PROD_W'(bank_r[cnt_r[BANK_AW-1:0]]);
    rnd     = acc_r + ACC_W'(RND_HALF);
    shifted = rnd >>> RND_SH;
    if (shifted > ACC_W'(32767)) begin
      sum_o = 16'sh7FFF;
    end else if (shifted < -ACC_W'(32768)) begin
      sum_o = -16'sh8000;
    end else begin
      sum_o = PRE_W'(shifted);
    end
  end

  // Accumulator control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (start_i) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      cnt_r   <= '0;
      acc_r   <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + ACC_W'(prod);
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == terms_i - 1'b1) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  assign valid_o = valid_r;

endmodule

// ----- src/sensor_mlp_wheel_drive_unit.sv -----
// Top level: weight writes, input scaling, tanh lanes, neuron lanes and speed output.
// An evaluate beat (8-4-2 network) runs input scaling, a tanh pass in every lane,
// the hidden neurons' serial accumulate (NUM_IN terms), a second tanh pass,
// the output neurons' accumulate (NUM_HIDDEN terms), a third pass, the speed stage.
// Beats are taken only in idle, so one evaluate ends before the next one starts.
// Reset: synchronous; all weight banks clear to zero at once, no clearing pass.
`include "sensor_mlp_wheel_drive_unit_macros.svh"

module sensor_mlp_wheel_drive_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  smwd_pkg::idx_t    in_weight_index,
  input  smwd_pkg::win_t    in_weight_value,
  input  smwd_pkg::sensor_t in_sensor_0,
  input  smwd_pkg::sensor_t in_sensor_1,
  input  smwd_pkg::sensor_t in_sensor_2,
  input  smwd_pkg::sensor_t in_sensor_3,
  input  smwd_pkg::sensor_t in_sensor_4,
  input  smwd_pkg::sensor_t in_sensor_5,
  input  smwd_pkg::sensor_t in_sensor_6,
  input  smwd_pkg::sensor_t in_sensor_7,
  output logic              out_valid,
  input  logic              out_stall,
  output smwd_pkg::speed_t  out_left_speed,
  output smwd_pkg::speed_t  out_right_speed
);
  import smwd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE1, ST_SCALE2, ST_WAIT_IN, ST_MAC_HID,
    ST_WAIT_HID, ST_MAC_OUT, ST_WAIT_OUT, ST_SPEED
  } state_t;

  state_t       state_r;
  sensor_t      sens_r [NUM_IN];
  logic [44:0]  rprod_r [NUM_IN];
  act_t         act_r [BANK_DEPTH];
  logic [22:0]  sprod_r [NUM_OUT];
  logic         sneg_r [NUM_OUT];
  logic         out_valid_r;
  speed_t       left_r;
  speed_t       right_r;

  logic         in_acc;
  sensor_t      sens_in [NUM_IN];
  logic [21:0]  nval [NUM_IN];
  pre_t         scale_val [NUM_IN];
  weight_t      wsat;
  idx_t         rel;
  wr_t          hid_wr [NUM_HIDDEN];
  wr_t          out_wr [NUM_OUT];
  logic         tanh_go;
  pre_t         tanh_x [BANK_DEPTH];
  act_t         tanh_res [BANK_DEPTH];
  logic [BANK_DEPTH-1:0] tanh_vld;
  logic         hid_go;
  logic         out_go;
  pre_t         hid_sum [NUM_HIDDEN];
  pre_t         out_sum [NUM_OUT];
  logic [NUM_HIDDEN-1:0] hid_vld;
  logic [NUM_OUT-1:0]    out_vld;
  logic         tanh_all;
  logic         load_out;
  speed_t       spd [NUM_OUT];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign sens_in[0] = in_sensor_0;
  assign sens_in[1] = in_sensor_1;
  assign sens_in[2] = in_sensor_2;
  assign sens_in[3] = in_sensor_3;
  assign sens_in[4] = in_sensor_4;
  assign sens_in[5] = in_sensor_5;
  assign sens_in[6] = in_sensor_6;
  assign sens_in[7] = in_sensor_7;

  // Weight write decode into the per-neuron banks.
  always_comb begin
    wsat = sat_weight(in_weight_value);
    rel  = in_weight_index - IDX_W'(OUT_BASE);
    for (int j = 0; j < NUM_HIDDEN; j++) begin
      hid_wr[j].en   = in_acc && !in_mode && (in_weight_index < IDX_W'(OUT_BASE)) &&
                       (IDX_W'(in_weight_index >> 3) == IDX_W'(j));
      hid_wr[j].addr = BANK_AW'(in_weight_index[2:0]);
      hid_wr[j].data = wsat;
    end
    out_wr[0].en   = in_acc && !in_mode && (in_weight_index >= IDX_W'(OUT_BASE)) &&
                     (rel < IDX_W'(NUM_HIDDEN));
    out_wr[0].addr = BANK_AW'(rel);
    out_wr[0].data = wsat;
    out_wr[1].en   = in_acc && !in_mode && (in_weight_index < IDX_W'(STORE_DEPTH)) &&
                     (in_weight_index >= IDX_W'(OUT_BASE)) && (rel >= IDX_W'(NUM_HIDDEN));
    out_wr[1].addr = BANK_AW'(rel - IDX_W'(NUM_HIDDEN));
    out_wr[1].data = wsat;
  end

  // Input scaling: reciprocal multiply registered, then one correction step.
  always_comb begin
    for (int i = 0; i < NUM_IN; i++) begin
      logic [14:0] q0;
      logic [21:0] rem;
      logic [14:0] q;
      nval[i] = {10'(sens_r[i] - SENSOR_W'(SCALE_LO)), 12'b0} + 22'(SCALE_OFS);
      q0      = rprod_r[i][44:RECIP_SH];
      rem     = nval[i] - 22'(q0) * 22'(DIV_C);
      q       = (rem >= 22'(DIV_C)) ? q0 + 1'b1 : q0;
      if (sens_r[i] <= SENSOR_W'(SCALE_LO)) begin
        scale_val[i] = -pre_t'(SCALE_FULL);
      end else if (sens_r[i] >= SENSOR_W'(SCALE_HI)) begin
        scale_val[i] = pre_t'(SCALE_FULL);
      end else begin
        scale_val[i] = PRE_W'(17'(q) - 17'(SCALE_FULL));
      end
    end
  end

  // Tanh lane operands for each layer.
  always_comb begin
    tanh_go = (state_r == ST_SCALE2) || ((state_r == ST_MAC_HID) && (&hid_vld)) ||
              ((state_r == ST_MAC_OUT) && (&out_vld));
    for (int i = 0; i < BANK_DEPTH; i++) begin
      tanh_x[i] = '0;
      unique case (state_r)
        ST_SCALE2:  if (i < NUM_IN) tanh_x[i] = scale_val[i];
        ST_MAC_HID: if (i < NUM_HIDDEN) tanh_x[i] = hid_sum[i];
        ST_MAC_OUT: if (i < NUM_OUT) tanh_x[i] = out_sum[i];
        default:    tanh_x[i] = '0;
      endcase
    end
  end

  assign tanh_all = &tanh_vld;
  assign hid_go   = (state_r == ST_WAIT_IN) && tanh_all;
  assign out_go   = (state_r == ST_WAIT_HID) && tanh_all;

  // Tanh lanes.
  for (genvar g = 0; g < BANK_DEPTH; g++) begin : g_tanh
    smwd_tanh u_tanh (
      .clk     (clk),
      .rst_n   (rst_n),
      .start_i (tanh_go),
      .x_i     (tanh_x[g]),
      .res_o   (tanh_res[g]),
      .valid_o (tanh_vld[g])
    );
  end

  // Hidden neuron lanes.
  for (genvar g = 0; g < NUM_HIDDEN; g++) begin : g_hid
    smwd_neuron u_hid (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_i    (hid_wr[g]),
      .start_i (hid_go),
      .terms_i (CNT_W'(NUM_IN)),
      .act_i   (act_r),
      .sum_o   (hid_sum[g]),
      .valid_o (hid_vld[g])
    );
  end

  // Output neuron lanes.
  for (genvar g = 0; g < NUM_OUT; g++) begin : g_out
    smwd_neuron u_out (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_i    (out_wr[g]),
      .start_i (out_go),
      .terms_i (CNT_W'(NUM_HIDDEN)),
      .act_i   (act_r),
      .sum_o   (out_sum[g]),
      .valid_o (out_vld[g])
    );
  end

  // Merge stage: round the scaled outputs to wheel speeds.
  always_comb begin
    for (int o = 0; o < NUM_OUT; o++) begin
      logic [10:0] mag;
      mag    = 11'((sprod_r[o] + 23'd2048) >> 12);
      spd[o] = sneg_r[o] ? -speed_t'(mag) : speed_t'(mag);
    end
  end

  assign load_out = (state_r == ST_SPEED) && (!out_valid_r || !out_stall);

  // Sequencer and data registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        left_r      <= spd[0];
        right_r     <= spd[1];
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_mode) begin
            for (int i = 0; i < NUM_IN; i++) begin
              sens_r[i] <= sens_in[i];
            end
            state_r <= ST_SCALE1;
          end
        end
        ST_SCALE1: begin
          for (int i = 0; i < NUM_IN; i++) begin
            rprod_r[i] <= 45'(nval[i]) * 45'(RECIP_M);
          end
          state_r <= ST_SCALE2;
        end
        ST_SCALE2: state_r <= ST_WAIT_IN;
        ST_WAIT_IN: begin
          if (tanh_all) begin
            act_r   <= tanh_res;
            state_r <= ST_MAC_HID;
          end
        end
        ST_MAC_HID: if (&hid_vld) state_r <= ST_WAIT_HID;
        ST_WAIT_HID: begin
          if (tanh_all) begin
            act_r   <= tanh_res;
            state_r <= ST_MAC_OUT;
          end
        end
        ST_MAC_OUT: if (&out_vld) state_r <= ST_WAIT_OUT;
        ST_WAIT_OUT: begin
          if (tanh_all) begin
            for (int o = 0; o < NUM_OUT; o++) begin
              sneg_r[o]  <= tanh_res[o][ACT_W-1];
              sprod_r[o] <= 23'(tanh_res[o][ACT_W-1] ? -tanh_res[o] : tanh_res[o]) *
                            23'(SPEED_SCALE);
            end
            state_r <= ST_SPEED;
          end
        end
        ST_SPEED: if (load_out) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_speed  = left_r;
  assign out_right_speed = right_r;

  `SMWD_NEXT(a_eval_starts, in_acc && in_mode, state_r == ST_SCALE1, "evaluate beat did not start scaling")
  `SMWD_NEXT(a_write_idle, in_acc && !in_mode, state_r == ST_IDLE, "weight write left the idle state")
  `SMWD_HOLD(a_speed_range, out_valid, (out_left_speed <= SPEED_MAX) && (out_left_speed >= -SPEED_MAX) && (out_right_speed <= SPEED_MAX) && (out_right_speed >= -SPEED_MAX), "wheel speed out of range")

endmodule

// ----- tb/tb_wheel_drive_checker.sv -----
// Checker for the wheel drive unit: predicts wheel speeds and compares each result beat.
`timescale 1ns / 100ps

module tb_wheel_drive_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_mode,
  input  smwd_pkg::idx_t    in_weight_index,
  input  smwd_pkg::win_t    in_weight_value,
  input  smwd_pkg::sensor_t in_sensor [8],
  input  logic              out_valid,
  input  logic              out_stall,
  input  smwd_pkg::speed_t  out_left_speed,
  input  smwd_pkg::speed_t  out_right_speed,
  output int                fail_count,
  output int                pending_count,
  output int                speed_count
);
  import smwd_pkg::*;

  typedef struct {
    speed_t left;
    speed_t right;
  } speed_pair_t;

  longint      net_weights [STORE_DEPTH];
  speed_pair_t speed_queue [$];

  // Linear map of a raw reading onto [-2.5, 2.5] in Q12.
  function automatic longint scale_reading(input sensor_t raw);
    longint v;
    v = raw;
    if (v <= SCALE_LO) return -SCALE_FULL;
    if (v >= SCALE_HI) return SCALE_FULL;
    return (20480 * (v - 50) + 475) / 950 - SCALE_FULL;
  endfunction

  // Pade approximation of tanh in Q12, saturating at |x| >= 3.
  function automatic longint tanh_fixed(input longint x);
    longint a, s, d, r;
    a = (x < 0) ? -x : x;
    if (a >= TANH_SAT) begin
      r = ONE_Q12;
    end else begin
      s = a * a;
      d = (longint'(27) << 24) + 9 * s;
      r = (a * ((longint'(27) << 24) + s) + d / 2) / d;
    end
    return (x < 0) ? -r : r;
  endfunction

  // Weighted sum rounded to Q12, saturated to 16 bits, then tanh.
  function automatic longint fire_neuron(input longint acc);
    longint q;
    q = acc + RND_HALF;
    q = q >>> RND_SH;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return tanh_fixed(q);
  endfunction

  function automatic speed_t speed_of(input longint y);
    longint a, s;
    a = (y < 0) ? -y : y;
    s = (a * 1000 + 2048) / 4096;
    return speed_t'((y < 0) ? -s : s);
  endfunction

  // Full forward pass of the 8-4-2 network on one sensor set.
  function automatic speed_pair_t predict_speeds();
    longint      first [NUM_IN];
    longint      hid [NUM_HIDDEN];
    longint      outn [NUM_OUT];
    longint      acc;
    speed_pair_t p;
    for (int i = 0; i < NUM_IN; i++) first[i] = tanh_fixed(scale_reading(in_sensor[i]));
    for (int h = 0; h < NUM_HIDDEN; h++) begin
      acc = 0;
      for (int i = 0; i < NUM_IN; i++) acc += first[i] * net_weights[h * NUM_IN + i];
      hid[h] = fire_neuron(acc);
    end
    for (int o = 0; o < NUM_OUT; o++) begin
      acc = 0;
      for (int h = 0; h < NUM_HIDDEN; h++)
        acc += hid[h] * net_weights[OUT_BASE + o * NUM_HIDDEN + h];
      outn[o] = fire_neuron(acc);
    end
    p.left  = speed_of(outn[0]);
    p.right = speed_of(outn[1]);
    return p;
  endfunction

  assign pending_count = speed_queue.size();

  // Track weight writes and compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    speed_pair_t want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) net_weights[i] = 0;
      speed_queue.delete();
      fail_count  <= 0;
      speed_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (!in_mode) begin
          if (in_weight_index < STORE_DEPTH) net_weights[in_weight_index] = in_weight_value;
        end else begin
          speed_queue.insert(speed_queue.size(), predict_speeds());
        end
      end
      if (out_valid && !out_stall) begin
        speed_count <= speed_count + 1;
        if (speed_queue.size() == 0) begin
          $error("result beat with no prediction waiting");
          errs++;
        end else begin
          want = speed_queue.pop_front();
          if (want.left !== out_left_speed) begin
            $error("left_speed: expected %0d, got %0d", want.left, out_left_speed);
            errs++;
          end
          if (want.right !== out_right_speed) begin
            $error("right_speed: expected %0d, got %0d", want.right, out_right_speed);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- tb/tb_top.sv -----
// Top of the wheel drive unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import smwd_pkg::*;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_mode = 1'b0;
  idx_t    in_weight_index = '0;
  win_t    in_weight_value = '0;
  sensor_t in_sensor [8];
  logic    out_stall = 1'b0;
  logic    in_stall, out_valid;
  speed_t  out_left_speed, out_right_speed;
  int      fail_count, pending_count, speed_count;
  int      cycle_count = 0;
  int      item_count = 0;
  bit      long_hold = 1'b0;
  bit      gaps_on = 1'b1;

  initial for (int i = 0; i < 8; i++) in_sensor[i] = '0;

  sensor_mlp_wheel_drive_unit DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_weight_index, .in_weight_value,
    .in_sensor_0(in_sensor[0]), .in_sensor_1(in_sensor[1]), .in_sensor_2(in_sensor[2]),
    .in_sensor_3(in_sensor[3]), .in_sensor_4(in_sensor[4]), .in_sensor_5(in_sensor[5]),
    .in_sensor_6(in_sensor[6]), .in_sensor_7(in_sensor[7]),
    .out_valid, .out_stall, .out_left_speed, .out_right_speed
  );

  tb_wheel_drive_checker checker_inst (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_weight_index, .in_weight_value,
    .in_sensor, .out_valid, .out_stall, .out_left_speed, .out_right_speed,
    .fail_count, .pending_count, .speed_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous limit for 1050 items plus gaps and stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall runs, one long hold-off, and stretches with none.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        @(posedge clk);
      end else if (!gaps_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(0, 13);
        out_stall <= (n != 0);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk iff out_valid);
      end
    end
  end

  // Offer one beat and hold it until accepted, after a random gap.
  task automatic send_beat(input logic mode, input idx_t idx, input win_t w,
                           input sensor_t s [8]);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_weight_index <= idx;
    in_weight_value <= w;
    for (int i = 0; i < 8; i++) in_sensor[i] <= s[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  task automatic send_weight(input idx_t idx, input win_t w);
    sensor_t s [8];
    for (int i = 0; i < 8; i++) s[i] = sensor_t'($urandom);
    send_beat(1'b0, idx, w, s);
  endtask

  task automatic send_sensors(input sensor_t s [8]);
    send_beat(1'b1, idx_t'($urandom), win_t'($urandom), s);
  endtask

  // Sensor readings that favor the edges of the scaling window.
  function automatic sensor_t pick_reading();
    case ($urandom_range(0, 5))
      0: return sensor_t'($urandom_range(0, 60));
      1: return sensor_t'($urandom_range(990, 1010));
      2: return sensor_t'($urandom);
      default: return sensor_t'($urandom_range(50, 1000));
    endcase
  endfunction

  // Weight values ranging from small to full scale.
  function automatic win_t pick_weight();
    case ($urandom_range(0, 3))
      0: return win_t'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return win_t'($signed($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  initial begin
    sensor_t s [8];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: evaluate on the cleared store, then field extremes.
    for (int i = 0; i < 8; i++) s[i] = '0;
    send_sensors(s);
    send_weight(6'd0, 16'sh7fff);
    send_weight(6'd39, 16'sh8000);
    send_weight(6'd40, 16'sh1234);
    send_weight(6'd63, 16'sh7fff);
    for (int i = 0; i < STORE_DEPTH; i++) send_weight(idx_t'(i), (i % 2) ? 16'sh7fff : 16'sh8000);
    for (int i = 0; i < 8; i++) s[i] = 12'hfff;
    send_sensors(s);
    for (int i = 0; i < 8; i++) s[i] = (i % 2) ? 12'd50 : 12'd1000;
    send_sensors(s);
    for (int i = 0; i < 8; i++) s[i] = (i % 2) ? 12'd51 : 12'd999;
    send_sensors(s);
    for (int i = 0; i < 8; i++) s[i] = 12'd525;
    send_sensors(s);

    // Random: mostly small weight bursts followed by sensor sets.
    while (item_count < 1050) begin
      if (item_count > 300 && item_count < 340) gaps_on = 1'b0;
      else gaps_on = 1'b1;
      if (item_count >= 600 && item_count < 602) long_hold = 1'b1;
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 15) == 0) send_weight(idx_t'($urandom_range(40, 63)), pick_weight());
        else send_weight(idx_t'($urandom_range(0, 39)), pick_weight());
      end
      for (int i = 0; i < 8; i++) s[i] = pick_reading();
      send_sensors(s);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d beats; %0d wheel speed results checked.", item_count, speed_count);
    $display("Covered weight writes incl. out-of-range slots, window edges and stalls.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+src
src/smwd_pkg.sv
src/smwd_tanh.sv
src/smwd_neuron.sv
src/sensor_mlp_wheel_drive_unit.sv
tb/tb_wheel_drive_checker.sv
tb/tb_top.sv
